// File: design/stec_pkg.sv
// Shared types and constants of the symbol table engine.
// Request, response and internal command layouts, request and status codes.
// No dependencies.
package stec_pkg;

   localparam int KEY_BITS       = 64;
   localparam int NINTH_BITS     = 8;
   localparam int VALUE_BITS     = 32;
   localparam int CODE_BITS      = 3;
   localparam int RSP_COUNT_BITS = 6;
   localparam int NAME_MAX_BYTES = 16;
   localparam int NAME_MAX_BITS  = NAME_MAX_BYTES * 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CODE_BITS-1:0] REQ_CLEAR   = 3'd0;
   localparam logic [CODE_BITS-1:0] REQ_CHECKED = 3'd1;
   localparam logic [CODE_BITS-1:0] REQ_PLAIN   = 3'd2;
   localparam logic [CODE_BITS-1:0] REQ_LOOKUP  = 3'd3;
   localparam logic [CODE_BITS-1:0] REQ_MODIFY  = 3'd4;

   localparam logic [CODE_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [CODE_BITS-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [CODE_BITS-1:0] ST_FULL      = 3'd2;
   localparam logic [CODE_BITS-1:0] ST_DIGIT     = 3'd3;
   localparam logic [CODE_BITS-1:0] ST_DUP       = 3'd4;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef struct packed {
      logic [CODE_BITS-1:0]         req_type;
      logic [KEY_BITS-1:0]          key_first8;
      logic [NINTH_BITS-1:0]        key_ninth;
      logic signed [VALUE_BITS-1:0] item_value;
      logic [KEY_BITS-1:0]          new_key_first8;
      logic [NINTH_BITS-1:0]        new_key_ninth;
   } request_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]         status;
      logic [RSP_COUNT_BITS-1:0]    location;
      logic signed [VALUE_BITS-1:0] found_value;
      logic [RSP_COUNT_BITS-1:0]    entry_count;
   } response_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]         req_code;
      logic [NAME_MAX_BITS-1:0]     name;
      logic [NAME_MAX_BITS-1:0]     new_name;
      logic signed [VALUE_BITS-1:0] value;
      logic                         digit;
   } command_type;

   typedef struct packed {
      logic        empty;
      command_type data;
   } queue_head_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_EXEC,
      BACK_SCAN
   } back_state_type;

endpackage

// File: design/stec_front.sv
// Front end of the symbol table engine: accepts requests and turns them into commands.
// Normalizes both names and flags a leading digit. Depends on stec_pkg.
module stec_front #(
   parameter int NAME_BYTES = 9
) (
   input  logic                  req_push,
   input  stec_pkg::request_type req_data,
   output logic                  req_full,
   input  logic                  q_full,
   output logic                  q_push,
   output stec_pkg::command_type q_data
);

   localparam int MaxBits = stec_pkg::NAME_MAX_BITS;

   function automatic logic [MaxBits-1:0] norm_name(
      input logic [stec_pkg::KEY_BITS-1:0]   first8,
      input logic [stec_pkg::NINTH_BITS-1:0] ninth
   );
      logic [MaxBits-1:0] result;
      logic               ended;
      logic [7:0]         b;
      result = '0;
      ended  = 1'b0;
      for (int k = 0; k < stec_pkg::NAME_MAX_BYTES; k++) begin
         if (k < 8) begin
            b = first8[63-8*k -: 8];
         end else if (k == 8) begin
            b = ninth;
         end else begin
            b = 8'h00;
         end
         if (k >= NAME_BYTES || ended) begin
            b = 8'h00;
         end
         if (b == 8'h00) begin
            ended = 1'b1;
         end
         result[MaxBits-1-8*k -: 8] = b;
      end
      return result;
   endfunction

   logic [MaxBits-1:0] name;

   always_comb begin
      name            = norm_name(req_data.key_first8, req_data.key_ninth);
      q_data.req_code = req_data.req_type;
      q_data.name     = name;
      q_data.new_name = norm_name(req_data.new_key_first8, req_data.new_key_ninth);
      q_data.value    = req_data.item_value;
      q_data.digit    = (name[MaxBits-1 -: 8] >= stec_pkg::CHAR_ZERO) &&
                        (name[MaxBits-1 -: 8] <= stec_pkg::CHAR_NINE);
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

endmodule

// File: design/stec_queue.sv
// Short command queue between the front end and the back end.
// Depends on stec_pkg for the command layout and depth.
module stec_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  stec_pkg::command_type    push_data,
   output logic                     full,
   input  logic                     pop,
   output stec_pkg::queue_head_type head
);

   localparam int Depth    = stec_pkg::QUEUE_DEPTH;
   localparam int PtrBits  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int FillBits = $clog2(Depth + 1);
   localparam logic [PtrBits-1:0]  LastPtr   = PtrBits'(Depth - 1);
   localparam logic [FillBits-1:0] DepthFill = FillBits'(Depth);

   stec_pkg::command_type slot_ff [Depth];
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FillBits-1:0]   fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full      = (fill_ff == DepthFill);
   assign head.empty = (fill_ff == '0);
   assign head.data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !head.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/stec_back.sv
// Back end of the symbol table engine: executes commands against the table memory.
// Linear scan with one read port and one comparator, plus the response register.
// Depends on stec_pkg.
module stec_back #(
   parameter int TABLE_ENTRIES = 32,
   parameter int NAME_BYTES    = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stec_pkg::queue_head_type head,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output stec_pkg::response_type   rsp_data
);

   localparam int NameBits  = NAME_BYTES * 8;
   localparam int MaxBits   = stec_pkg::NAME_MAX_BITS;
   localparam int AddrBits  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CountBits = $clog2(TABLE_ENTRIES + 1);
   localparam int RspBits   = stec_pkg::RSP_COUNT_BITS;
   localparam int ValBits   = stec_pkg::VALUE_BITS;
   localparam logic [CountBits-1:0] Capacity = CountBits'(TABLE_ENTRIES);
   localparam logic [CountBits-1:0] One      = CountBits'(1);

   logic [NameBits-1:0]       name_mem  [TABLE_ENTRIES];
   logic signed [ValBits-1:0] value_mem [TABLE_ENTRIES];

   stec_pkg::back_state_type  state_ff, state_in;
   stec_pkg::command_type     cmd_ff, cmd_in;
   logic [CountBits-1:0]      count_ff, count_in;
   logic [AddrBits-1:0]       iss_idx_ff, iss_idx_in;
   logic                      issuing_ff, issuing_in;
   logic [AddrBits-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                      cmp_valid_ff, cmp_valid_in;
   logic [NameBits-1:0]       name_rd_ff;
   logic signed [ValBits-1:0] value_rd_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   stec_pkg::response_type    rsp_ff, rsp_in;

   logic                      wr_en;
   logic [AddrBits-1:0]       wr_addr;
   logic [NameBits-1:0]       wr_name;
   logic signed [ValBits-1:0] wr_value;
   logic                      rsp_load;
   logic [stec_pkg::CODE_BITS-1:0] res_status;
   logic [CountBits-1:0]      res_loc;
   logic signed [ValBits-1:0] res_value;
   logic [NameBits-1:0]       key;
   logic [CountBits-1:0]      count_plus, iss_next, cmp_loc;
   logic                      match;

   assign key        = cmd_ff.name[MaxBits-1 -: NameBits];
   assign count_plus = count_ff + One;
   assign iss_next   = CountBits'(iss_idx_ff) + One;
   assign cmp_loc    = CountBits'(cmp_idx_ff) + One;
   assign match      = (name_rd_ff == key);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      iss_idx_in   = iss_idx_ff;
      issuing_in   = issuing_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AddrBits-1:0];
      wr_name      = key;
      wr_value     = cmd_ff.value;
      rsp_load     = 1'b0;
      res_status   = stec_pkg::ST_OK;
      res_loc      = '0;
      res_value    = '0;

      unique case (state_ff)
         stec_pkg::BACK_IDLE: begin
            if (!head.empty && (!rsp_valid_ff || rsp_pop)) begin
               q_pop    = 1'b1;
               cmd_in   = head.data;
               state_in = stec_pkg::BACK_EXEC;
            end
         end
         stec_pkg::BACK_EXEC: begin
            state_in = stec_pkg::BACK_IDLE;
            rsp_load = 1'b1;
            unique case (cmd_ff.req_code) inside
               stec_pkg::REQ_CLEAR: begin
                  count_in = '0;
               end
               stec_pkg::REQ_CHECKED, stec_pkg::REQ_PLAIN: begin
                  if (count_ff == Capacity) begin
                     res_status = stec_pkg::ST_FULL;
                  end else if (cmd_ff.req_code == stec_pkg::REQ_CHECKED && cmd_ff.digit) begin
                     res_status = stec_pkg::ST_DIGIT;
                  end else if (cmd_ff.req_code == stec_pkg::REQ_CHECKED && count_ff != '0) begin
                     rsp_load   = 1'b0;
                     iss_idx_in = '0;
                     issuing_in = 1'b1;
                     state_in   = stec_pkg::BACK_SCAN;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_plus;
                     res_loc  = count_plus;
                  end
               end
               stec_pkg::REQ_LOOKUP, stec_pkg::REQ_MODIFY: begin
                  if (count_ff == '0) begin
                     res_status = stec_pkg::ST_NOT_FOUND;
                  end else begin
                     rsp_load   = 1'b0;
                     iss_idx_in = '0;
                     issuing_in = 1'b1;
                     state_in   = stec_pkg::BACK_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         stec_pkg::BACK_SCAN: begin
            if (issuing_ff) begin
               iss_idx_in   = AddrBits'(iss_next);
               issuing_in   = (iss_next < count_ff);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = iss_idx_ff;
            end
            if (cmp_valid_ff && (match || cmp_loc == count_ff)) begin
               issuing_in   = 1'b0;
               cmp_valid_in = 1'b0;
               rsp_load     = 1'b1;
               state_in     = stec_pkg::BACK_IDLE;
               if (match) begin
                  case (cmd_ff.req_code)
                     stec_pkg::REQ_CHECKED: begin
                        res_status = stec_pkg::ST_DUP;
                     end
                     stec_pkg::REQ_MODIFY: begin
                        wr_en     = 1'b1;
                        wr_addr   = cmp_idx_ff;
                        wr_name   = cmd_ff.new_name[MaxBits-1 -: NameBits];
                        res_loc   = cmp_loc;
                        res_value = value_rd_ff;
                     end
                     default: begin
                        res_loc   = cmp_loc;
                        res_value = value_rd_ff;
                     end
                  endcase
               end else if (cmd_ff.req_code == stec_pkg::REQ_CHECKED) begin
                  wr_en    = 1'b1;
                  count_in = count_plus;
                  res_loc  = count_plus;
               end else begin
                  res_status = stec_pkg::ST_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = stec_pkg::BACK_IDLE;
         end
      endcase

      rsp_in.status      = res_status;
      rsp_in.location    = RspBits'(res_loc);
      rsp_in.found_value = res_value;
      rsp_in.entry_count = RspBits'(count_in);
      rsp_valid_in       = rsp_load || (rsp_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stec_pkg::BACK_IDLE;
         count_ff     <= '0;
         issuing_ff   <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issuing_ff   <= issuing_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      iss_idx_ff <= iss_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr]  <= wr_name;
         value_mem[wr_addr] <= wr_value;
      end
      name_rd_ff  <= name_mem[iss_idx_ff];
      value_rd_ff <= value_mem[iss_idx_ff];
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/symbol_table_engine_core.sv
// Symbol table engine: a table of named values searched linearly from the first entry.
// Use: requests are pushed on the req_ channel while req_full is low; each request gives
// exactly one response, popped on the rsp_ channel while rsp_empty is low, in order.
// Requests are clear, checked insert, plain insert, lookup and modify. Names are
// zero padded ASCII; locations are 1-based and 0 means none.
// Clear, plain insert, an insert rejected for a full table or a leading digit, and a
// request on an empty table are answered without a search. A request that searches
// the table reads one entry per cycle through the single read port of the table
// memory into one comparator, and the back end works on one request at a time.
// A two-entry command queue lets requests be pushed while the back end is busy
// or while a response waits; when the response is not popped, the back end holds
// and the queue fills, then req_full rises.
// Reset (synchronous, active high) empties the table and both channels; the table
// memory needs no clearing pass.
// Depends on stec_pkg, stec_front, stec_queue and stec_back.
module symbol_table_engine_core #(
   parameter int TABLE_ENTRIES = 32,
   parameter int NAME_BYTES    = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  stec_pkg::request_type  req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output stec_pkg::response_type rsp_data
);

   logic                     q_full;
   logic                     q_push;
   logic                     q_pop;
   stec_pkg::command_type    q_data;
   stec_pkg::queue_head_type q_head;

   stec_front #(
      .NAME_BYTES(NAME_BYTES)
   ) u_front (
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_data)
   );

   stec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_data),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   stec_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .NAME_BYTES   (NAME_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("channels not empty after reset");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (TABLE_ENTRIES < 64) && !rsp_empty && rsp_data.status == stec_pkg::ST_FULL
      |-> rsp_data.entry_count == TABLE_ENTRIES)
      else $error("full status with a table that is not full");

   a_loc_bound: assert property (@(posedge clock) disable iff (reset)
      (TABLE_ENTRIES < 64) && !rsp_empty && rsp_data.location != 0
      |-> rsp_data.location <= rsp_data.entry_count && rsp_data.status == stec_pkg::ST_OK)
      else $error("response location outside the stored entries");
`endif

endmodule
